// ----- rtl/target_counter_seven_segment_defines.svh -----
// ---------------------------------------------------------------------------
// Target counter seven segment: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TARGET_COUNTER_SEVEN_SEGMENT_DEFINES_SVH
`define TARGET_COUNTER_SEVEN_SEGMENT_DEFINES_SVH

// Same-cycle implication
`define TCSS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcss same-cycle check failed");

// Next-cycle implication
`define TCSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcss next-cycle check failed");

`endif

// ----- rtl/tcss_pkg.sv -----
// ---------------------------------------------------------------------------
// tcss_pkg
// Types, constants and digit helpers for the target counter display.
// ---------------------------------------------------------------------------
package tcss_pkg;

    localparam int SEG_W      = 7;
    localparam int VALUE_W    = 7;
    localparam int DIGIT_W    = 4;
    localparam int PRESCALE_W = 6;

    typedef logic [SEG_W-1:0]      seg_t;
    typedef logic [VALUE_W-1:0]    value_t;
    typedef logic [DIGIT_W-1:0]    digit_t;
    typedef logic [PRESCALE_W-1:0] prescale_t;

    localparam value_t    VALUE_MAX         = 7'd99;
    localparam prescale_t TICK_DIVIDE_RESET = 6'd5;

    // divide by ten as multiply by 205, shift by 11 (exact below 1029)
    localparam logic [7:0] DIV10_MUL   = 8'd205;
    localparam int         DIV10_SHIFT = 11;
    localparam int         PROD_W      = VALUE_W + 8;

    // one pass worth of display data
    typedef struct packed {
        seg_t units_seg;
        seg_t tens_seg;
        logic lamp;
        logic running;
    } pass_result_t;

    // segment pattern, bit0 = a .. bit6 = g
    function automatic seg_t seg_of(digit_t d);
        seg_t s;
        unique case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7C;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h67;
            default: s = 7'h3F;
        endcase
        return s;
    endfunction

    function automatic digit_t tens_of(value_t v);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(v) * PROD_W'(DIV10_MUL);
        return prod[DIV10_SHIFT +: DIGIT_W];
    endfunction

    // tens times ten as tens times eight plus tens times two
    function automatic digit_t units_of(value_t v, digit_t tens);
        value_t tens_x10;
        tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
        return DIGIT_W'(v - tens_x10);
    endfunction

endpackage

// ----- rtl/tcss_core.sv -----
// ---------------------------------------------------------------------------
// tcss_core
// Target/count state, prescaler and digit decode for one loop pass.
// ---------------------------------------------------------------------------
module tcss_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [5:0]                   cfg_data,
    input  logic                         step,
    input  logic                         up,
    input  logic                         down,
    input  logic                         start,
    output tcss_pkg::pass_result_t       result
);

    tcss_pkg::prescale_t tick_divide_reg;
    tcss_pkg::value_t    target_reg, target_next;
    tcss_pkg::value_t    count_reg, count_next;
    tcss_pkg::prescale_t prescale_reg, prescale_next;
    logic                run_reg, run_next;
    logic                lamp_reg, lamp_next;

    tcss_pkg::value_t    target_up, target_dn, count_s, shown, shown_clamp;
    tcss_pkg::digit_t    tens_digit, units_digit;
    logic                run_s, lamp_s, fire;

    // target adjust, start, counting step
    always_comb
    begin
        target_up = (up && (target_reg < tcss_pkg::VALUE_MAX)) ? target_reg + 7'd1 : target_reg;
        target_dn = (down && (target_up != '0)) ? target_up - 7'd1 : target_up;
        count_s   = start ? '0 : count_reg;
        run_s     = start | run_reg;
        lamp_s    = start ? 1'b0 : lamp_reg;
        fire      = prescale_reg >= tick_divide_reg;

        target_next   = target_dn;
        count_next    = count_s;
        prescale_next = prescale_reg;
        run_next      = run_s;
        lamp_next     = lamp_s;
        shown         = target_dn;

        if (run_s)
        begin
            if (fire)
            begin
                count_next = (count_s >= tcss_pkg::VALUE_MAX) ? '0 : count_s + 7'd1;
            end
            prescale_next = (fire ? '0 : prescale_reg) + 6'd1;
            shown         = count_next;
            if (count_next == target_dn)
            begin
                run_next    = 1'b0;
                target_next = '0;
                lamp_next   = 1'b1;
            end
        end
    end

    // digit split and segment decode
    always_comb
    begin
        shown_clamp = (shown > tcss_pkg::VALUE_MAX) ? tcss_pkg::VALUE_MAX : shown;
        tens_digit  = tcss_pkg::tens_of(shown_clamp);
        units_digit = tcss_pkg::units_of(shown_clamp, tens_digit);
        result.units_seg = tcss_pkg::seg_of(units_digit);
        result.tens_seg  = tcss_pkg::seg_of(tens_digit);
        result.lamp      = lamp_next;
        result.running   = run_next;
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_divide_reg <= tcss_pkg::TICK_DIVIDE_RESET;
        end
        else if (cfg_write)
        begin
            tick_divide_reg <= cfg_data;
        end
    end

    // state, updated once per pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= '0;
            count_reg    <= '0;
            prescale_reg <= '0;
            run_reg      <= 1'b0;
            lamp_reg     <= 1'b0;
        end
        else if (step)
        begin
            target_reg   <= target_next;
            count_reg    <= count_next;
            prescale_reg <= prescale_next;
            run_reg      <= run_next;
            lamp_reg     <= lamp_next;
        end
    end

endmodule

// ----- rtl/target_counter_seven_segment.sv -----
// An accepted item waits in the input register until the result register is
//   free; its units result then shows, its tens one output transfer later.
// Each item puts two results on the output channel, which out_stall can hold;
//   the input register takes the next item meanwhile.
// Reset: asynchronous active low; target, count, prescaler, run and lamp clear,
//   tick_divide returns to 5, both channels empty.
// ---------------------------------------------------------------------------
// target_counter_seven_segment
// Two-digit target counter; each item is one loop pass, results are the
// units then tens seven-segment patterns.
// ---------------------------------------------------------------------------
`include "target_counter_seven_segment_defines.svh"

module target_counter_seven_segment
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_write,
    input  logic [5:0] cfg_data,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       up_press,
    input  logic       down_press,
    input  logic       start_press,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] segments,
    output logic       digit_tens,
    output logic       last,
    output logic       lamp,
    output logic       running
);

    logic in_vld_reg, in_vld_next;
    logic up_reg, down_reg, start_reg;
    logic pass_vld_reg, pass_vld_next;
    logic half_reg, half_next;
    tcss_pkg::pass_result_t pass_reg, result;

    logic in_fire, out_fire, pass_free, load;

    // handshake control
    assign out_fire  = pass_vld_reg && !out_stall;
    assign pass_free = !pass_vld_reg || (out_fire && half_reg);
    assign load      = in_vld_reg && pass_free;
    assign in_stall  = in_vld_reg && !load;
    assign in_fire   = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next   = in_fire || (in_vld_reg && !load);
        pass_vld_next = pass_vld_reg;
        half_next     = half_reg;
        if (load)
        begin
            pass_vld_next = 1'b1;
            half_next     = 1'b0;
        end
        else if (out_fire)
        begin
            pass_vld_next = !half_reg;
            half_next     = 1'b1;
        end
    end

    // pass logic, runs when the item moves into the result register
    tcss_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .step      (load),
        .up        (up_reg),
        .down      (down_reg),
        .start     (start_reg),
        .result    (result)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            pass_vld_reg <= 1'b0;
            half_reg     <= 1'b0;
        end
        else
        begin
            in_vld_reg   <= in_vld_next;
            pass_vld_reg <= pass_vld_next;
            half_reg     <= half_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            up_reg    <= up_press;
            down_reg  <= down_press;
            start_reg <= start_press;
        end
        if (load)
        begin
            pass_reg <= result;
        end
    end

    // result outputs: units first, then tens
    assign out_valid  = pass_vld_reg;
    assign segments   = half_reg ? pass_reg.tens_seg : pass_reg.units_seg;
    assign digit_tens = half_reg;
    assign last       = half_reg;
    assign lamp       = pass_reg.lamp;
    assign running    = pass_reg.running;

    // checks
    `TCSS_ASSERT_NEXT(a_tens_follows_units, out_fire && !last, out_valid && last)
    `TCSS_ASSERT_NEXT(a_new_pass_starts_units, out_fire && last, !out_valid || !last)
    `TCSS_ASSERT_IMP(a_lamp_run_exclusive, out_valid, !(lamp && running))
    `TCSS_ASSERT_IMP(a_load_needs_item, load, in_vld_reg && (!pass_vld_reg || half_reg))

endmodule

// ----- tb/tb_target_counter_seven_segment.sv -----
// ---------------------------------------------------------------------------
// tb_target_counter_seven_segment
// Self-checking bench for the two-digit target counter. Each item is one loop
// pass; a local model of target, count, prescaler, run and lamp predicts the
// units and tens segment results of every accepted pass, and a monitor checks
// each result in order under random sender idling and receiver stalls.
// ---------------------------------------------------------------------------
module tb_target_counter_seven_segment;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_CHUNK = 330;

    // one expected display result
    typedef struct packed {
        tcss_pkg::seg_t segs;
        logic tens;
        logic is_last;
        logic lamp;
        logic run;
    } digit_result_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    logic [5:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic       up_press;
    logic       down_press;
    logic       start_press;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [6:0] segments;
    logic       digit_tens;
    logic       last;
    logic       lamp;
    logic       running;

    // model state
    tcss_pkg::value_t    target_val;
    tcss_pkg::value_t    count_val;
    tcss_pkg::prescale_t prescale_val;
    tcss_pkg::prescale_t tick_div;
    logic                run_on;
    logic                lamp_on;

    digit_result_t display_q[$];
    digit_result_t want_res;

    int fail_count;
    int items_sent;
    int idle_cycles;
    int in_idle_pct;
    int out_stall_pct;

    target_counter_seven_segment u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .up_press    (up_press),
        .down_press  (down_press),
        .start_press (start_press),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .segments    (segments),
        .digit_tens  (digit_tens),
        .last        (last),
        .lamp        (lamp),
        .running     (running)
    );

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // segment pattern of one decimal digit, bit0 = a .. bit6 = g
    function automatic tcss_pkg::seg_t digit_pattern(int digit);
        case (digit)
            0:       return 7'h3F;
            1:       return 7'h06;
            2:       return 7'h5B;
            3:       return 7'h4F;
            4:       return 7'h66;
            5:       return 7'h6D;
            6:       return 7'h7C;
            7:       return 7'h07;
            8:       return 7'h7F;
            9:       return 7'h67;
            default: return 7'h3F;
        endcase
    endfunction

    // advance the model by one pass and queue its units and tens results
    function automatic void predict_pass(logic up, logic dn, logic st);
        tcss_pkg::value_t shown;
        digit_result_t    res;
        if (up && target_val < tcss_pkg::VALUE_MAX)
            target_val = target_val + 1'b1;
        if (dn && target_val > 0)
            target_val = target_val - 1'b1;
        if (st)
        begin
            count_val = '0;
            run_on    = 1'b1;
            lamp_on   = 1'b0;
        end
        if (run_on)
        begin
            // prescaler fires at or above the divide, count wraps past 99
            if (prescale_val >= tick_div)
            begin
                count_val    = (count_val >= tcss_pkg::VALUE_MAX) ?
                               tcss_pkg::value_t'(0) : count_val + 1'b1;
                prescale_val = '0;
            end
            prescale_val = prescale_val + 1'b1;
            shown        = count_val;
            if (count_val == target_val)
            begin
                run_on     = 1'b0;
                target_val = '0;
                lamp_on    = 1'b1;
            end
        end
        else
            shown = target_val;
        if (shown > tcss_pkg::VALUE_MAX)
            shown = tcss_pkg::VALUE_MAX;
        res.segs    = digit_pattern(int'(shown) % 10);
        res.tens    = 1'b0;
        res.is_last = 1'b0;
        res.lamp    = lamp_on;
        res.run     = run_on;
        display_q.push_back(res);
        res.segs    = digit_pattern(int'(shown) / 10);
        res.tens    = 1'b1;
        res.is_last = 1'b1;
        display_q.push_back(res);
    endfunction

    // offer one pass, with random idle cycles ahead of it
    task automatic send_pass(input logic up, input logic dn, input logic st);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid    <= 1'b0;
            up_press    <= 1'($urandom_range(0, 1));
            down_press  <= 1'($urandom_range(0, 1));
            start_press <= 1'($urandom_range(0, 1));
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        up_press    <= up;
        down_press  <= dn;
        start_press <= st;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predict_pass(up, dn, st);
        items_sent++;
    endtask

    // write tick_divide once every pending result is out
    task automatic set_tick_divide(input int value);
        in_valid <= 1'b0;
        while (display_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= 6'(value);
        @(posedge clk);
        tick_div  = tcss_pkg::prescale_t'(value);
        cfg_write <= 1'b0;
    endtask

    // press edge cases at the reset divide of 5
    task automatic test_directed_passes();
        send_pass(1'b0, 1'b0, 1'b0);
        send_pass(1'b0, 1'b1, 1'b0);    // down at zero
        send_pass(1'b1, 1'b1, 1'b0);    // up and down together
        send_pass(1'b0, 1'b0, 1'b1);    // start with target zero stops at once
        send_pass(1'b1, 1'b0, 1'b0);
        send_pass(1'b1, 1'b0, 1'b0);
        send_pass(1'b1, 1'b0, 1'b1);    // up and start in one pass
        repeat (6) send_pass(1'b0, 1'b0, 1'b0);
        send_pass(1'b0, 1'b0, 1'b1);    // restart while running
        send_pass(1'b1, 1'b1, 1'b1);
        send_pass(1'b0, 1'b1, 1'b0);    // target moved during the run
    endtask

    // target pinned at 99, then a full run to 98 at divide 0
    task automatic test_target_saturation();
        int n;
        set_tick_divide(0);
        repeat (103) send_pass(1'b1, 1'b0, 1'b0);
        send_pass(1'b1, 1'b1, 1'b0);
        send_pass(1'b0, 1'b0, 1'b1);
        n = 0;
        while (run_on && n < 200)
        begin
            send_pass(1'b0, 1'b0, 1'b0);
            n++;
        end
        repeat (3) send_pass(1'b0, 1'b1, 1'b0);
    endtask

    // target lowered under the count, so the count wraps through zero
    task automatic test_count_wrap();
        int n;
        set_tick_divide(1);
        repeat (30) send_pass(1'b1, 1'b0, 1'b0);
        send_pass(1'b0, 1'b0, 1'b1);
        repeat (10) send_pass(1'b0, 1'b0, 1'b0);
        repeat (25) send_pass(1'b0, 1'b1, 1'b0);
        n = 0;
        while (run_on && n < 300)
        begin
            send_pass(1'b0, 1'b0, 1'b0);
            n++;
        end
    endtask

    // slowest divide, then lowered under the prescaler mid-run
    task automatic test_divide_change();
        int n;
        set_tick_divide(63);
        repeat (5) send_pass(1'b1, 1'b0, 1'b0);
        send_pass(1'b0, 1'b0, 1'b1);
        repeat (70) send_pass(1'b0, 1'b0, 1'b0);
        set_tick_divide(2);
        n = 0;
        while (run_on && n < 100)
        begin
            send_pass(1'b0, 1'b0, 1'b0);
            n++;
        end
    endtask

    // one random round: maybe change the divide, then pure noise, or set target, start, count with some noise
    task automatic run_round();
        int kind;
        int n;
        int cap;
        kind = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
        begin
            case ($urandom_range(0, 9))
                0:       set_tick_divide(0);
                1:       set_tick_divide(63);
                2:       set_tick_divide($urandom_range(4, 62));
                default: set_tick_divide($urandom_range(1, 3));
            endcase
        end
        // pure noise round
        if (kind == 3)
        begin
            repeat ($urandom_range(5, 30))
                send_pass(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 3) == 0));
        end
        else
        begin
            n = (kind == 0) ? $urandom_range(95, 110) : $urandom_range(0, 15);
            repeat (n) send_pass(1'b1, 1'($urandom_range(0, 9) == 0), 1'b0);
            send_pass(1'($urandom_range(0, 7) == 0), 1'($urandom_range(0, 7) == 0), 1'b1);
            cap = (kind == 2) ? 400 : 160;
            n   = 0;
            while (run_on && n < cap)
            begin
                if (kind == 2 && n == 6)
                    repeat ($urandom_range(1, 20)) send_pass(1'b0, 1'b1, 1'b0);
                else
                    send_pass(1'($urandom_range(0, 99) < 4), 1'($urandom_range(0, 99) < 4),
                              1'($urandom_range(0, 99) < 2));
                n++;
            end
            repeat ($urandom_range(0, 3))
                send_pass(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
        end
    endtask

    task automatic test_random_rounds();
        int start_count;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_CHUNK)
            run_round();
    endtask

    // receiver stall
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < out_stall_pct);

    // result checker
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (display_q.size() == 0)
            begin
                $error("unexpected result: segments %0h", segments);
                fail_count++;
            end
            else
            begin
                want_res = display_q.pop_front();
                if (segments !== want_res.segs)
                begin
                    $error("segments: expected %0h, actual %0h", want_res.segs, segments);
                    fail_count++;
                end
                if (digit_tens !== want_res.tens)
                begin
                    $error("digit_tens: expected %0d, actual %0d", want_res.tens, digit_tens);
                    fail_count++;
                end
                if (last !== want_res.is_last)
                begin
                    $error("last: expected %0d, actual %0d", want_res.is_last, last);
                    fail_count++;
                end
                if (lamp !== want_res.lamp)
                begin
                    $error("lamp: expected %0d, actual %0d", want_res.lamp, lamp);
                    fail_count++;
                end
                if (running !== want_res.run)
                begin
                    $error("running: expected %0d, actual %0d", want_res.run, running);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0) || rst_n !== 1'b1)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        fail_count    = 0;
        items_sent    = 0;
        idle_cycles   = 0;
        target_val    = '0;
        count_val     = '0;
        prescale_val  = '0;
        tick_div      = tcss_pkg::TICK_DIVIDE_RESET;
        run_on        = 1'b0;
        lamp_on       = 1'b0;
        in_idle_pct   = 13;
        out_stall_pct = 73;
        rst_n       <= 1'b0;
        cfg_write   <= 1'b0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        up_press    <= 1'b0;
        down_press  <= 1'b0;
        start_press <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_passes();
        test_target_saturation();
        test_random_rounds();

        in_idle_pct   = 73;
        out_stall_pct = 13;
        test_count_wrap();
        test_random_rounds();

        in_idle_pct   = 0;
        out_stall_pct = 0;
        test_divide_change();
        test_random_rounds();

        // drain and settle
        in_valid <= 1'b0;
        while (display_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES * 2) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- target_counter_seven_segment.f -----
+incdir+rtl
rtl/tcss_pkg.sv
rtl/tcss_core.sv
rtl/target_counter_seven_segment.sv
tb/tb_target_counter_seven_segment.sv
